// ===== sv/ctc_greedy_decoder_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef CTC_GREEDY_DECODER_MACROS_SVH
`define CTC_GREEDY_DECODER_MACROS_SVH

// Same-cycle implication, sampled on aclk and off during reset.
`define CTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ctc check failed");

// Next-cycle implication, sampled on aclk and off during reset.
`define CTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ctc check failed");

`endif

// ===== sv/ctc_pkg.sv =====
package ctc_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } ctc_state_t;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic signed [15:0] SCORE_MIN = 16'sh8000;
    localparam int DIV_STEPS = 33;
    localparam int SYM_W = 13;
    localparam int CONF_W = 16;

    // 2^(-k/16) in Q16 for k = 0..16.
    function automatic logic [16:0] pow2_lut(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ctc_exp_unit.sv =====
module ctc_exp_unit
    import ctc_pkg::*;
#(
    parameter int IDXW = 13
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic                   in_last,
    input  logic [IDXW-1:0]        in_idx,
    input  logic signed [15:0]     in_score,
    input  logic signed [15:0]     in_max,
    output logic                   out_valid,
    output logic                   out_last,
    output logic [IDXW-1:0]        out_idx,
    output logic [16:0]            out_exp
);

    logic [2:0]       v_reg, v_next;
    logic [2:0]       l_reg;
    logic [IDXW-1:0]  i1_reg, i2_reg, i3_reg;
    logic [32:0]      y_reg;
    logic [16:0]      m_reg;
    logic [8:0]       n_reg;
    logic [16:0]      e_reg;

    logic [15:0] gap;
    logic [3:0]  k;
    logic [11:0] r;
    logic [16:0] tk, tk1, diff, m_next;
    logic [28:0] prod;

    assign gap  = 16'(17'(in_max) - 17'(in_score));
    assign k    = y_reg[23:20];
    assign r    = y_reg[19:8];
    assign tk   = pow2_lut({1'b0, k});
    assign tk1  = pow2_lut(5'(k) + 5'd1);
    assign diff = tk - tk1;
    assign prod = diff * r;
    assign m_next = tk - 17'(prod >> 12);
    assign v_next = {v_reg[1:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg  <= {l_reg[1:0], in_last};
        i1_reg <= in_idx;
        i2_reg <= i1_reg;
        i3_reg <= i2_reg;
        y_reg  <= gap * LOG2E_Q16;
        m_reg  <= m_next;
        n_reg  <= y_reg[32:24];
        // Beyond 2^-16 the result underflows to zero.
        e_reg  <= (n_reg > 9'd16) ? 17'd0 : (m_reg >> n_reg[4:0]);
    end

    assign out_valid = v_reg[2];
    assign out_last  = l_reg[2];
    assign out_idx   = i3_reg;
    assign out_exp   = e_reg;

endmodule

// ===== sv/ctc_div_unit.sv =====
module ctc_div_unit
    import ctc_pkg::*;
#(
    parameter int SUMW = 30
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [SUMW-1:0] divisor,
    output logic            done,
    output logic [15:0]     quotient
);

    logic            busy_reg;
    logic            done_reg;
    logic [5:0]      cnt_reg;
    logic [SUMW:0]   rem_reg;
    logic [16:0]     q_reg;
    logic [SUMW-1:0] div_reg;

    logic [SUMW:0] rem_sh;
    logic          ge;

    // Dividend is 2^32: a one followed by 32 zero bits.
    assign rem_sh = {rem_reg[SUMW-1:0], (cnt_reg == 6'd0)};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            q_reg   <= {q_reg[15:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[16] ? 16'hFFFF : q_reg[15:0];

endmodule

// ===== sv/ctc_greedy_decoder.sv =====
// Channel | Dir | tdata (low bit up)               | tlast    | tuser
// s_      | in  | logit[15:0]                      | step_end | sequence_start
// m_      | out | symbol_index[12:0], conf[28:13]  | -        | -
//
// Scores load at one per cycle into the row memory. On the step end the row
// is read back through the exponential pipeline, one score per cycle; then
// the 33-step divider forms the confidence. s_tready thus stays low from the
// step end until the divider is done, and beyond that while a symbol goes
// out and waits on m_tready.
// Reset is synchronous on aresetn low; the row memory needs no clearing.
// While a result waits for m_tready the input stays stalled.
module ctc_greedy_decoder
    import ctc_pkg::*;
#(
    parameter int MAX_CLASSES = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // logit
    input  logic        s_tlast,
    input  logic        s_tuser,   // sequence_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // symbol_index, confidence, zero pad
);

    localparam int IDXW = $clog2(MAX_CLASSES);
    localparam int CNTW = $clog2(MAX_CLASSES + 1);
    localparam int SUMW = IDXW + 17;

    ctc_state_t state_reg, state_next;

    logic signed [15:0] row_mem [MAX_CLASSES];

    logic [CNTW-1:0]    row_count_reg;
    logic signed [15:0] row_max_reg;
    logic [SYM_W-1:0]   prev_best_reg;
    logic               first_reg;
    logic [CNTW-1:0]    issue_reg;
    logic               rd_valid_reg, rd_last_reg;
    logic [IDXW-1:0]    rd_idx_reg;
    logic signed [15:0] rd_data_reg;
    logic [SUMW-1:0]    sum_reg;
    logic [IDXW-1:0]    best_reg;
    logic [16:0]        best_val_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [CONF_W-1:0]  conf_reg;

    logic               accept, room, issue_en, issue_last, emit;
    logic               e_valid, e_last, div_start, div_done;
    logic [IDXW-1:0]    e_idx;
    logic [16:0]        e_val;
    logic [SUMW-1:0]    sum_upd;
    logic [15:0]        div_q;
    logic signed [15:0] score;

    assign score      = s_tdata;
    assign accept     = s_tvalid && s_tready;
    assign room       = row_count_reg < CNTW'(MAX_CLASSES);
    assign issue_last = issue_reg == (row_count_reg - CNTW'(1));
    assign sum_upd    = sum_reg + SUMW'(e_val);
    assign emit       = (best_reg != '0) &&
                        (first_reg || (SYM_W'(best_reg) != prev_best_reg));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (accept && s_tlast) state_next = ST_PASS;
            ST_PASS:  if (issue_last) state_next = ST_DRAIN;
            ST_DRAIN: if (e_valid && e_last) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = emit ? ST_OUT : ST_LOAD;
            ST_OUT:   if (m_tready) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_tready  = state_reg == ST_LOAD;
        issue_en  = state_reg == ST_PASS;
        m_tvalid  = state_reg == ST_OUT;
        div_start = (state_reg == ST_DRAIN) && e_valid && e_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            row_count_reg <= '0;
            row_max_reg   <= SCORE_MIN;
            prev_best_reg <= '0;
            first_reg     <= 1'b1;
            issue_reg     <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue_en;
            if (accept) begin
                if (s_tuser) first_reg <= 1'b1;
                if (room) begin
                    row_count_reg <= row_count_reg + CNTW'(1);
                    if (score > row_max_reg) row_max_reg <= score;
                end
                issue_reg <= '0;
            end
            if (issue_en) issue_reg <= issue_reg + CNTW'(1);
            if (div_done) begin
                prev_best_reg <= SYM_W'(best_reg);
                first_reg     <= 1'b0;
                row_count_reg <= '0;
                row_max_reg   <= SCORE_MIN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && room) row_mem[row_count_reg[IDXW-1:0]] <= score;
        rd_data_reg <= row_mem[issue_reg[IDXW-1:0]];
        rd_idx_reg  <= issue_reg[IDXW-1:0];
        rd_last_reg <= issue_last;
    end

    // Running sum and first argmax over the exponentials, and the output latch.
    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            sum_reg      <= '0;
            best_reg     <= '0;
            best_val_reg <= '0;
        end else if (e_valid) begin
            sum_reg <= sum_upd;
            if (e_val > best_val_reg) begin
                best_val_reg <= e_val;
                best_reg     <= e_idx;
            end
        end
        if (div_done && emit) begin
            sym_reg  <= SYM_W'(best_reg - IDXW'(1));
            conf_reg <= div_q;
        end
    end

    ctc_exp_unit #(.IDXW(IDXW)) u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .in_last   (rd_last_reg),
        .in_idx    (rd_idx_reg),
        .in_score  (rd_data_reg),
        .in_max    (row_max_reg),
        .out_valid (e_valid),
        .out_last  (e_last),
        .out_idx   (e_idx),
        .out_exp   (e_val)
    );

    ctc_div_unit #(.SUMW(SUMW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (sum_upd),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tdata = {3'b000, conf_reg, sym_reg};

endmodule

// ===== sv/ctc_chk.sv =====
`include "ctc_greedy_decoder_macros.svh"

module ctc_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `CTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CTC_ASSERT_NOW(a_out_blocks_in, m_tvalid, !s_tready)
    `CTC_ASSERT_NEXT(a_load_continues, s_tvalid && s_tready && !s_tlast, s_tready)
    `CTC_ASSERT_NEXT(a_step_end_busy, s_tvalid && s_tready && s_tlast, !s_tready && !m_tvalid)

endmodule

bind ctc_greedy_decoder ctc_chk u_chk (.*);
